### src/cmtk_pkg.sv
// Shared types and constants for the column mean top-k block.
// No dependencies; used by the channel interfaces and the core.
package cmtk_pkg;

	localparam int MAX_DIM    = 4096;
	localparam int MAX_TOKENS = 4096;
	localparam int K_MAX      = 64;

	localparam int DIM_W   = 12;  // element / dimension index
	localparam int CNT_W   = 13;  // token count and dim_in_use, holds MAX_DIM itself
	localparam int SUM_W   = 44;  // per-dimension sum
	localparam int VAL_W   = 32;  // Q16.16 sample and mean
	localparam int RANK_W  = 6;
	localparam int TOPC_W  = 7;
	localparam int DVD_W   = SUM_W + 1;  // |sum| + count/2
	localparam int DIVC_W  = 6;          // divider step counter

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	localparam logic [0:0] OP_ACCUMULATE = 1'b0;
	localparam logic [0:0] OP_FINISH     = 1'b1;

	localparam logic [0:0] CFG_TOP_COUNT  = 1'b0;
	localparam logic [0:0] CFG_DIM_IN_USE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,  // post-reset clearing sweep of the sum memory
		ST_IDLE,
		ST_ACC,    // read data back, add and write
		ST_RD,     // finish sweep: read entry, write zero
		ST_DATA,   // finish sweep: sum available
		ST_DIV,    // mean divider running
		ST_INS,    // insert into ranked list
		ST_EMIT    // hand out the ranked list
	} cmtk_state_t;

	typedef struct packed {
		logic [DIM_W-1:0]        idx;
		logic signed [VAL_W-1:0] mean;
		logic [VAL_W-1:0]        mag;
	} cmtk_entry_t;

endpackage

### src/cmtk_ifs.sv
// Valid/ready channel interfaces for the column mean top-k block.
// Depends on cmtk_pkg for field widths.
interface cmtk_in_if import cmtk_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic [0:0]              operation;
	logic [DIM_W-1:0]        element_index;
	logic signed [VAL_W-1:0] value;
	modport source (output valid, operation, element_index, value, input ready);
	modport sink   (input valid, operation, element_index, value, output ready);
endinterface

interface cmtk_out_if import cmtk_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic [RANK_W-1:0]       rank;
	logic [DIM_W-1:0]        dim_index;
	logic signed [VAL_W-1:0] mean_value;
	logic                    last;
	modport source (output valid, rank, dim_index, mean_value, last, input ready);
	modport sink   (input valid, rank, dim_index, mean_value, last, output ready);
endinterface

interface cmtk_cfg_if import cmtk_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [0:0]       index;
	logic [CNT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### src/column_mean_top_k_magnitude_core.sv
// Column mean top-k core: sum memory, mean divider and ranked list.
// Depends on cmtk_pkg and the channel interfaces in cmtk_ifs.sv.
//
// Usage:
//  in_ch  : transactions of operation/element_index/value. Accumulate adds a
//           Q16.16 value into the 44-bit saturating sum of its dimension; a
//           token is counted when element dim_in_use-1 is taken. Elements at
//           or past dim_in_use, or after MAX_TOKENS tokens, are dropped.
//           Finish ranks the dimensions in use by |mean| and clears all sums.
//  out_ch : one transaction per reported dimension after a finish, rank 0
//           first, last set on the final one; min(top_count, dim_in_use).
//  cfg    : register writes (index 0 top_count, index 1 dim_in_use), always
//           ready; write only while the block is idle.
// Sequence: an accumulate reads the memory, then adds and writes back
//  through the single sum memory port pair. A finish sweeps all 4096
//  memory entries (read and clear, then data), with an insert step for
//  each dimension in use and a pass of the bit-serial mean divider for
//  each dimension in use when tokens were counted, then hands out one
//  result per cycle while out_ch.ready is high.
// Reset: a clearing pass zeroes all 4096 sum memory entries; in_ch.ready
//  stays low until it is done. A stalled receiver simply holds the current
//  result; no input is taken until the whole list has been delivered.
module column_mean_top_k_magnitude_core import cmtk_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	cmtk_in_if.sink          in_ch,
	cmtk_out_if.source       out_ch,
	cmtk_cfg_if.sink         cfg
);

	cmtk_state_t state_q, state_d;

	// configuration
	logic [TOPC_W-1:0] top_count_q;
	logic [CNT_W-1:0]  dim_in_use_q;

	// sum memory
	logic signed [SUM_W-1:0] sum_mem [MAX_DIM];
	logic signed [SUM_W-1:0] mem_rd_q;
	logic [DIM_W-1:0]        mem_ra, mem_wa;
	logic                    mem_we;
	logic signed [SUM_W-1:0] mem_wd;

	logic [CNT_W-1:0] token_count_q;
	logic [DIM_W-1:0] sweep_q;

	// accumulate transaction held across the read
	logic [DIM_W-1:0]        acc_idx_q;
	logic signed [VAL_W-1:0] acc_val_q;
	logic                    acc_drop_q;

	// divider
	logic [DVD_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [DIVC_W-1:0] div_cnt_q;
	logic              neg_q;

	// ranked list, a row of shift cells
	cmtk_entry_t       list_q [K_MAX];
	logic [TOPC_W-1:0] n_q;
	logic [RANK_W-1:0] rank_q;

	// derived
	logic [CNT_W-1:0]  dim_eff;
	logic [TOPC_W-1:0] k1, k_eff, k_m1;
	logic              in_acc, in_fin, out_acc;
	logic              sweep_last, sweep_in_use;
	logic [SUM_W:0]    acc_sum;
	logic signed [SUM_W-1:0] acc_sat;
	logic [SUM_W-1:0]  sum_mag;
	logic [CNT_W:0]    rem_n;
	logic              div_ge;
	logic [VAL_W-1:0]  new_mag;
	cmtk_entry_t       new_e;
	logic [K_MAX-1:0]  cmp;
	logic              inserted;

	// clamp registers to their legal ranges
	always_comb begin
		if (dim_in_use_q == '0)
			dim_eff = CNT_W'(1);
		else if (dim_in_use_q > CNT_W'(MAX_DIM))
			dim_eff = CNT_W'(MAX_DIM);
		else
			dim_eff = dim_in_use_q;
		if (top_count_q == '0)
			k1 = TOPC_W'(1);
		else if (top_count_q > TOPC_W'(K_MAX))
			k1 = TOPC_W'(K_MAX);
		else
			k1 = top_count_q;
		if ({{(CNT_W-TOPC_W){1'b0}}, k1} > dim_eff)
			k_eff = dim_eff[TOPC_W-1:0];
		else
			k_eff = k1;
		k_m1 = k_eff - TOPC_W'(1);
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc  = in_ch.valid && in_ch.ready && (in_ch.operation == OP_ACCUMULATE);
	assign in_fin  = in_ch.valid && in_ch.ready && (in_ch.operation == OP_FINISH);
	assign out_acc = out_ch.valid && out_ch.ready;

	assign sweep_last   = (sweep_q == DIM_W'(MAX_DIM - 1));
	assign sweep_in_use = ({1'b0, sweep_q} < dim_eff);

	// saturating add of the accumulate path
	always_comb begin
		acc_sum = {mem_rd_q[SUM_W-1], mem_rd_q}
			+ {{(SUM_W+1-VAL_W){acc_val_q[VAL_W-1]}}, acc_val_q};
		if (acc_sum[SUM_W] != acc_sum[SUM_W-1])
			acc_sat = acc_sum[SUM_W] ? SUM_MIN : SUM_MAX;
		else
			acc_sat = acc_sum[SUM_W-1:0];
		sum_mag = mem_rd_q[SUM_W-1] ? (SUM_W'(0) - mem_rd_q) : mem_rd_q;
	end

	// one restoring divider step per cycle
	always_comb begin
		rem_n  = {rem_q, dvd_q[DVD_W-1]};
		div_ge = (rem_n >= {1'b0, token_count_q});
	end

	// rounded mean from the quotient, clamped to 32 bits signed
	always_comb begin
		if (neg_q)
			new_mag = (dvd_q > DVD_W'(33'h080000000)) ? 32'h80000000 : dvd_q[VAL_W-1:0];
		else
			new_mag = (dvd_q > DVD_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : dvd_q[VAL_W-1:0];
		new_e.idx  = sweep_q;
		new_e.mag  = new_mag;
		new_e.mean = neg_q ? (VAL_W'(0) - new_mag) : new_mag;
	end

	// slot compare; empty slots always lose, so cmp is thermometer coded
	always_comb begin
		for (int j = 0; j < K_MAX; j++)
			cmp[j] = (TOPC_W'(j) >= n_q) || (list_q[j].mag < new_e.mag);
		inserted = cmp[k_m1[RANK_W-1:0]];
	end

	// memory port control
	always_comb begin
		mem_ra = sweep_q;
		mem_wa = sweep_q;
		mem_we = 1'b0;
		mem_wd = '0;
		case (state_q)
			ST_CLEAR: mem_we = 1'b1;
			ST_IDLE:  mem_ra = in_ch.element_index;
			ST_ACC: begin
				mem_wa = acc_idx_q;
				mem_we = !acc_drop_q;
				mem_wd = acc_sat;
			end
			ST_RD:    mem_we = 1'b1;
			default:  mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			sum_mem[mem_wa] <= mem_wd;
		mem_rd_q <= sum_mem[mem_ra];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (sweep_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_acc)
					state_d = ST_ACC;
				else if (in_fin)
					state_d = ST_RD;
			end
			ST_ACC: state_d = ST_IDLE;
			ST_RD:  state_d = ST_DATA;
			ST_DATA: begin
				if (sweep_in_use)
					state_d = (token_count_q == '0) ? ST_INS : ST_DIV;
				else
					state_d = sweep_last ? ST_EMIT : ST_RD;
			end
			ST_DIV: if (div_cnt_q == DIVC_W'(DVD_W - 1)) state_d = ST_INS;
			ST_INS: state_d = sweep_last ? ST_EMIT : ST_RD;
			ST_EMIT: if (out_acc && out_ch.last) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_count_q  <= TOPC_W'(10);
			dim_in_use_q <= CNT_W'(MAX_DIM);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_TOP_COUNT:  top_count_q  <= cfg.data[TOPC_W-1:0];
				CFG_DIM_IN_USE: dim_in_use_q <= cfg.data;
				default:        top_count_q  <= top_count_q;
			endcase
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q       <= '0;
			token_count_q <= '0;
			n_q           <= '0;
			rank_q        <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: sweep_q <= sweep_q + DIM_W'(1);
				ST_IDLE: begin
					if (in_fin) begin
						sweep_q <= '0;
						n_q     <= '0;
					end
				end
				ST_ACC: begin
					if (!acc_drop_q && ({1'b0, acc_idx_q} == dim_eff - CNT_W'(1)))
						token_count_q <= token_count_q + CNT_W'(1);
				end
				ST_DATA: begin
					if (!sweep_in_use) begin
						sweep_q <= sweep_q + DIM_W'(1);
						if (sweep_last) begin
							token_count_q <= '0;
							rank_q        <= '0;
						end
					end
				end
				ST_INS: begin
					if (inserted && n_q < k_eff)
						n_q <= n_q + TOPC_W'(1);
					sweep_q <= sweep_q + DIM_W'(1);
					if (sweep_last) begin
						token_count_q <= '0;
						rank_q        <= '0;
					end
				end
				ST_EMIT: if (out_acc) rank_q <= rank_q + RANK_W'(1);
				default: rank_q <= rank_q;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			acc_idx_q  <= in_ch.element_index;
			acc_val_q  <= in_ch.value;
			acc_drop_q <= ({1'b0, in_ch.element_index} >= dim_eff)
				|| (token_count_q >= CNT_W'(MAX_TOKENS));
		end
		if (state_q == ST_DATA) begin
			neg_q     <= mem_rd_q[SUM_W-1] && (token_count_q != '0);
			rem_q     <= '0;
			div_cnt_q <= '0;
			if (token_count_q == '0)
				dvd_q <= '0;
			else
				dvd_q <= {1'b0, sum_mag} + DVD_W'(token_count_q >> 1);
		end
		if (state_q == ST_DIV) begin
			dvd_q     <= {dvd_q[DVD_W-2:0], div_ge};
			rem_q     <= div_ge ? CNT_W'(rem_n - {1'b0, token_count_q}) : rem_n[CNT_W-1:0];
			div_cnt_q <= div_cnt_q + DIVC_W'(1);
		end
		if (state_q == ST_INS && inserted) begin
			for (int j = 0; j < K_MAX; j++) begin
				if (cmp[j]) begin
					if (j == 0)
						list_q[j] <= new_e;
					else if (!cmp[j-1])
						list_q[j] <= new_e;
					else
						list_q[j] <= list_q[j-1];
				end
			end
		end
		if (state_q == ST_EMIT && out_acc) begin
			for (int j = 0; j < K_MAX - 1; j++)
				list_q[j] <= list_q[j+1];
		end
	end

	// result channel straight from the head cell
	assign out_ch.valid      = (state_q == ST_EMIT);
	assign out_ch.rank       = rank_q;
	assign out_ch.dim_index  = list_q[0].idx;
	assign out_ch.mean_value = list_q[0].mean;
	assign out_ch.last       = ({1'b0, rank_q} + TOPC_W'(1) == n_q);

	// no input is taken while results are pending
	a_no_in_during_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready)
		else $error("input ready while results pending");

	a_tokens_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		token_count_q <= CNT_W'(MAX_TOKENS))
		else $error("token count beyond limit");

	a_list_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= TOPC_W'(K_MAX))
		else $error("ranked list overfilled");

	a_last_ends_list: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && out_ch.last) |=> !out_ch.valid)
		else $error("result after last");

	a_finish_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		in_fin |=> (state_q == ST_RD && sweep_q == '0 && n_q == '0))
		else $error("finish did not start sweep at entry zero");

endmodule
